[rtl/des_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package des_pkg;

  localparam int unsigned NumRounds = 16;

  localparam logic [2:0] RegKey = 3'd0;

  typedef logic [7:0] idx_t;

  typedef struct packed {
    logic        vld;
    logic        dec;
    logic [31:0] left;
    logic [31:0] right;
    logic [27:0] kc;
    logic [27:0] kd;
  } rnd_t;

  localparam idx_t TabIp [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam idx_t TabFp [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam idx_t TabE [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam idx_t TabP [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

  localparam idx_t TabPc1 [56] = '{
    57,49,41,33,25,17,9,  1,58,50,42,34,26,18,
    10,2,59,51,43,35,27,  19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29,  21,13,5,28,20,12,4};

  localparam idx_t TabPc2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

  localparam logic [1:0] TabShift [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam logic [3:0] TabSbox [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(TabIp[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(TabFp[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] x);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = x[64-int'(TabPc1[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] x);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = x[56-int'(TabPc2[i])];
    return r;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [1:0] s);
    logic [27:0] r;
    r = (s == 2'd2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
    return r;
  endfunction

  function automatic logic [27:0] rotr28(input logic [27:0] v, input logic [1:0] s);
    logic [27:0] r;
    r = (s == 2'd2) ? {v[1:0], v[27:2]} : {v[0], v[27:1]};
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] e;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(TabE[i])];
    e = e ^ k;
    for (int i = 0; i < 8; i++) begin
      six = e[42-6*i +: 6];
      s[28-4*i +: 4] = TabSbox[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TabP[i])];
    return p;
  endfunction

endpackage
`default_nettype wire

[rtl/des_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface des_stream_if #(parameter int unsigned Width = 64);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/des_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module des_cell import des_pkg::*; #(
  parameter int unsigned Round = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire rnd_t din,
  output rnd_t      dout
);

  logic [27:0] c_enc, d_enc, c_use, d_use, c_dec, d_dec;
  logic [47:0] rkey;
  rnd_t        nxt;

  // encrypt rotates before use; decrypt uses then rotates right by the reversed schedule
  always_comb begin
    c_enc = rotl28(din.kc, TabShift[Round]);
    d_enc = rotl28(din.kd, TabShift[Round]);
    c_use = din.dec ? din.kc : c_enc;
    d_use = din.dec ? din.kd : d_enc;
    c_dec = rotr28(din.kc, TabShift[NumRounds-1-Round]);
    d_dec = rotr28(din.kd, TabShift[NumRounds-1-Round]);
    rkey  = perm_pc2({c_use, d_use});
    nxt.vld   = din.vld;
    nxt.dec   = din.dec;
    nxt.left  = din.right;
    nxt.right = din.left ^ feistel(din.right, rkey);
    nxt.kc    = din.dec ? c_dec : c_enc;
    nxt.kd    = din.dec ? d_dec : d_enc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= nxt.vld;
    end
    if (en) begin
      dout.dec   <= nxt.dec;
      dout.left  <= nxt.left;
      dout.right <= nxt.right;
      dout.kc    <= nxt.kc;
      dout.kd    <= nxt.kd;
    end
  end

endmodule
`default_nettype wire

[rtl/des_block_cipher_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// DES block cipher, ECB, one 64-bit block per transfer.
// in_ch : payload {action, block_in}; action 0 encrypts, 1 decrypts.
// out_ch: payload block_out.
// the key is written over the APB-style port, register 0 at byte address 0; the user
// must make writes only while no block is in flight; the core does not enforce it.
// a chain of sixteen round cells, one per Feistel round, each deriving its
// round key from the rotated key halves handed along with the block.
// from input transfer to result valid a block passes the entry stage applying IP
// (loaded at the transfer edge), then the sixteen cells, then the output
// register applying FP.
// throughput: one block per cycle; the whole chain advances when the output
// register is empty or taken, so a stalled receiver freezes the chain and
// deasserts in_ch.ready until the waiting result is taken.
// reset clears the key to zero and empties the chain.
module des_block_cipher_core import des_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  des_stream_if.sink         in_ch,
  des_stream_if.source       out_ch,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [0:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic      [63:0]   prdata,
  output logic               pready
);

  logic [63:0] cipher_key;
  rnd_t        chain [NumRounds+1];
  logic        en;
  logic        out_vld;
  logic [63:0] out_data;
  logic [63:0] ip_blk;
  logic [55:0] k56;
  logic [63:0] fp_blk;

  assign pready = 1'b1;
  assign prdata = (paddr == RegKey[0:0]) ? cipher_key : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= 64'd0;
    end else if (psel && penable && pwrite && paddr == RegKey[0:0]) begin
      cipher_key <= pwdata;
    end
  end

  // chain moves whenever the output slot is free or being taken
  logic any_bubble;
  always_comb begin
    any_bubble = !out_vld || out_ch.ready;
  end
  assign en          = any_bubble;
  assign in_ch.ready = en;

  assign ip_blk = perm_ip(in_ch.data[63:0]);
  assign k56    = perm_pc1(cipher_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else if (en) begin
      chain[0].vld <= in_ch.valid;
    end
    if (en) begin
      chain[0].dec   <= in_ch.data[64];
      chain[0].left  <= ip_blk[63:32];
      chain[0].right <= ip_blk[31:0];
      chain[0].kc    <= k56[55:28];
      chain[0].kd    <= k56[27:0];
    end
  end

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    des_cell #(.Round(g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  assign fp_blk = perm_fp({chain[NumRounds].right, chain[NumRounds].left});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= chain[NumRounds].vld;
    end
    if (en) begin
      out_data <= fp_blk;
    end
  end

  assign out_ch.valid = out_vld;
  assign out_ch.data  = out_data;

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_ch.ready |=> out_vld && $stable(out_data))
    else $error("result changed while stalled");
  a_no_accept_stall: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while chain frozen");
  a_first_cell: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> chain[0].vld)
    else $error("accepted block lost at chain entry");
`endif

endmodule
`default_nettype wire

[verif/des_cipher_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module des_cipher_checker import des_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  des_stream_if            in_mon,
  des_stream_if            out_mon,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [0:0]  paddr,
  input  wire logic [63:0] pwdata,
  output int               errors,
  output int               pending
);

  logic [63:0] key_model;
  logic [63:0] expected_blocks[$];

  function automatic logic [63:0] des_block(input logic [63:0] key, input logic dec,
                                            input logic [63:0] din);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [47:0] rk[16];
    logic [63:0] ip;
    logic [63:0] pre;
    logic [63:0] r;
    logic [31:0] lh;
    logic [31:0] rh;
    logic [31:0] t;
    logic [31:0] s;
    logic [31:0] f;
    logic [47:0] e;
    logic [5:0]  six;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(TabPc1[i])];
    c = cd[55:28];
    d = cd[27:0];
    for (int n = 0; n < 16; n++) begin
      for (int j = 0; j < int'(TabShift[n]); j++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cd = {c, d};
      for (int i = 0; i < 48; i++) rk[n][47-i] = cd[56-int'(TabPc2[i])];
    end
    for (int i = 0; i < 64; i++) ip[63-i] = din[64-int'(TabIp[i])];
    lh = ip[63:32];
    rh = ip[31:0];
    for (int n = 0; n < 16; n++) begin
      for (int i = 0; i < 48; i++) e[47-i] = rh[32-int'(TabE[i])];
      e = e ^ (dec ? rk[15-n] : rk[n]);
      for (int i = 0; i < 8; i++) begin
        six = e[47-6*i -: 6];
        s[31-4*i -: 4] = TabSbox[i][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) f[31-i] = s[32-int'(TabP[i])];
      t = rh;
      rh = lh ^ f;
      lh = t;
    end
    pre = {rh, lh};
    for (int i = 0; i < 64; i++) r[63-i] = pre[64-int'(TabFp[i])];
    return r;
  endfunction

  initial begin
    errors = 0;
    key_model = '0;
  end

  assign pending = expected_blocks.size();

  always @(posedge clk) begin
    if (rst) begin
      key_model = '0;
      expected_blocks.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_blocks.push_back(des_block(key_model, in_mon.data[64], in_mon.data[63:0]));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_blocks.size() == 0) begin
          $error("unexpected transfer: block_out actual %h", out_mon.data);
          errors++;
        end else begin
          logic [63:0] exp_blk;
          exp_blk = expected_blocks.pop_front();
          if (out_mon.data !== exp_blk) begin
            $error("block_out mismatch: expected %h actual %h", exp_blk, out_mon.data);
            errors++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == RegKey[0:0])
        key_model = pwdata;
    end
  end

endmodule
`default_nettype wire

[verif/des_block_cipher_core_test.sv]
`timescale 1ns / 1ps
`default_nettype none
module des_block_cipher_core_test;
  import des_pkg::*;

  localparam int StallLimit = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        idling = 1'b1;
  int          errors;
  int          pending;
  int          quiet_cycles = 0;

  des_stream_if #(.Width(65)) in_ch ();
  des_stream_if #(.Width(64)) out_ch ();

  des_block_cipher_core DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  des_cipher_checker checker_i (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: stall bursts while idling is on
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
  end

  task automatic write_key(input logic [63:0] k);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= RegKey[0:0];
    pwdata <= k;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one transfer; valid stays high between back-to-back items
  task automatic send_block(input logic act, input logic [63:0] blk);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {act, blk};
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] keys[8];
    logic [63:0] blk;
    keys[0] = 64'h0;
    keys[1] = '1;
    keys[2] = 64'h0101010101010101;
    keys[3] = 64'hFEFEFEFEFEFEFEFE;
    keys[4] = 64'h01FE01FE01FE01FE;
    keys[5] = rand64();
    keys[6] = rand64();
    keys[7] = rand64();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset key, then the textbook key
    send_block(1'b0, 64'h0);
    send_block(1'b1, '1);
    drain();
    write_key(64'h133457799BBCDFF1);
    send_block(1'b0, 64'h0123456789ABCDEF);
    send_block(1'b1, 64'h85E813540F0AB405);
    send_block(1'b0, 64'h0);
    send_block(1'b0, '1);
    send_block(1'b1, 64'hAAAAAAAAAAAAAAAA);
    send_block(1'b0, 64'h5555555555555555);
    send_block(1'b1, 64'h8000000000000001);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_key(keys[ph]);
      if (ph == 7) idling <= 1'b0;
      send_block(1'b0, '1);
      send_block(1'b1, 64'h0);
      for (int n = 0; n < 140; n++) begin
        blk = rand64();
        send_block(1'($urandom_range(0, 1)), blk);
        // now and then send the inverted block for decryption
        if ($urandom_range(0, 7) == 0) send_block(1'b1, ~blk);
      end
      drain();
    end

    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
rtl/des_pkg.sv
rtl/des_stream_if.sv
rtl/des_cell.sv
rtl/des_block_cipher_core.sv
verif/des_cipher_checker.sv
verif/des_block_cipher_core_test.sv
